### hdl/ldf_pkg.sv
// ---------------------------------------------------------------------------
// Length/checksum deframer package
// Shared types, command codes and register indexes for the deframer.
// ---------------------------------------------------------------------------
package ldf_pkg;

    // Default depth of the payload buffer.
    localparam int LDF_BUF_DEPTH = 256;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 8;

    // Command codes carried with each input transaction.
    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_DONE = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_VALUE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH   = 8'd1;

    // Register reset values and the rejected length.
    localparam logic [7:0] HEADER_RESET  = 8'hFF;
    localparam logic [7:0] MAX_LEN_RESET = 8'hFF;
    localparam logic [7:0] LEN_ZERO      = 8'h00;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
        logic [7:0] read_index;
    } t_in;

    // Result transaction payload.
    typedef struct packed {
        logic       packet_ready;
        logic [7:0] payload_size;
        logic [7:0] read_data;
    } t_out;

    // Packet status from the frame controller.
    typedef struct packed {
        logic       packet_ready;
        logic [7:0] payload_size;
    } t_status;

    // Buffer write request from the frame controller.
    typedef struct packed {
        logic       en;
        logic [7:0] addr;
        logic [7:0] data;
    } t_buf_wr;

endpackage

### hdl/ldf_buffer.sv
// ---------------------------------------------------------------------------
// Payload buffer
// Single-port-write, single-port-read synchronous memory with a registered
// read port.
// ---------------------------------------------------------------------------
module ldf_buffer
    import ldf_pkg::*;
#(
    parameter int BUF_DEPTH = LDF_BUF_DEPTH,
    parameter int AW        = (BUF_DEPTH > 2) ? $clog2(BUF_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [BUF_DEPTH];
    logic [7:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/ldf_ctrl.sv
// ---------------------------------------------------------------------------
// Frame controller
// Holds the configuration registers and the frame search state, adds up
// the checksum and issues payload writes into the buffer.
// ---------------------------------------------------------------------------
module ldf_ctrl
    import ldf_pkg::*;
#(
    parameter int BUF_DEPTH = LDF_BUF_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_take,
    input  logic [1:0]           i_cmd,
    input  logic [7:0]           i_data,
    output t_buf_wr              o_wr,
    output t_status              o_status
);

    typedef enum logic [2:0] {
        PH_WAIT_H1,
        PH_WAIT_H2,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_CHECK,
        PH_HOLD
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_expected, n_expected;
    logic [7:0] r_count, n_count;
    logic [7:0] r_header;
    logic [7:0] r_max_len;
    logic       byte_in;
    logic       count_in_buf;

    assign byte_in      = i_take && (i_cmd == CMD_BYTE);
    assign count_in_buf = ({1'b0, r_count} < 9'(BUF_DEPTH));

    // Configuration registers; indexes outside the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header  <= HEADER_RESET;
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_HEADER_VALUE: r_header  <= i_cfg_data;
                REG_MAX_LENGTH:   r_max_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next frame state for one received byte or a handled command.
    always_comb begin
        n_phase    = r_phase;
        n_sum      = r_sum;
        n_expected = r_expected;
        n_count    = r_count;
        if (i_take && (i_cmd == CMD_DONE)) begin
            n_phase = PH_WAIT_H1;
        end else if (byte_in) begin
            unique case (r_phase)
                PH_WAIT_H1: begin
                    if (i_data == r_header) begin
                        n_phase = PH_WAIT_H2;
                    end
                end
                PH_WAIT_H2: begin
                    n_phase = (i_data == r_header) ? PH_LENGTH : PH_WAIT_H1;
                end
                PH_LENGTH: begin
                    if ((i_data == LEN_ZERO) || (i_data > r_max_len)) begin
                        n_phase = PH_WAIT_H1;
                    end else begin
                        n_expected = i_data - 8'd1;
                        n_count    = 8'd0;
                        n_sum      = {r_header[6:0], 1'b0} + i_data;
                        n_phase    = (i_data == 8'd1) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_sum   = r_sum + i_data;
                    n_count = r_count + 8'd1;
                    if ((r_count + 8'd1) == r_expected) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    n_phase = (r_sum == i_data) ? PH_HOLD : PH_WAIT_H1;
                end
                PH_HOLD: begin
                    n_phase = PH_HOLD;
                end
                default: begin
                    n_phase = PH_WAIT_H1;
                end
            endcase
        end
    end

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WAIT_H1;
            r_sum      <= 8'd0;
            r_expected <= 8'd0;
            r_count    <= 8'd0;
        end else begin
            r_phase    <= n_phase;
            r_sum      <= n_sum;
            r_expected <= n_expected;
            r_count    <= n_count;
        end
    end

    // Payload bytes that fit the buffer are stored at their position.
    always_comb begin
        o_wr.en   = byte_in && (r_phase == PH_PAYLOAD) && count_in_buf;
        o_wr.addr = r_count;
        o_wr.data = i_data;
    end

    // Status seen by the result stage.
    always_comb begin
        o_status.packet_ready = (r_phase == PH_HOLD);
        o_status.payload_size = (r_phase == PH_HOLD) ? r_expected : 8'd0;
    end

endmodule

### hdl/length_checksum_packet_deframer.sv
// An accepted input passes the read stage and then the result register.
// Throughput: one transaction per cycle unless stalled, set by the single read port.
// The input stalls only while the read stage and the result register are both
// full and the result is stalled.
// Reset (synchronous, active low) clears the frame state and the handshake;
// header_value and max_length return to 255, the buffer contents are kept.
// ---------------------------------------------------------------------------
// Length/checksum packet deframer
// Finds header, length, payload and checksum frames in a byte stream,
// buffers the payload and answers each transaction with status and read data.
// ---------------------------------------------------------------------------
module length_checksum_packet_deframer
    import ldf_pkg::*;
#(
    parameter int BUF_DEPTH = LDF_BUF_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out
);

    localparam int AW = (BUF_DEPTH > 2) ? $clog2(BUF_DEPTH) : 1;

    t_buf_wr    wr;
    t_status    status;
    logic [7:0] rd_data;
    logic       accept;
    logic       out_free;
    logic       s1_move;
    logic       rd_in_buf;
    logic       r_s1_valid;
    logic       r_s1_read;
    logic       r_out_valid;
    t_out       r_out;

    assign o_cfg_ready = 1'b1;

    // Input handshake and stage movement.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign rd_in_buf  = ({1'b0, i_in.read_index} < 9'(BUF_DEPTH));

    ldf_ctrl #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_take     (accept),
        .i_cmd      (i_in.cmd),
        .i_data     (i_in.data_byte),
        .o_wr       (wr),
        .o_status   (status)
    );

    ldf_buffer #(
        .BUF_DEPTH(BUF_DEPTH),
        .AW       (AW)
    ) u_buffer (
        .i_clk    (i_clk),
        .i_wr_en  (wr.en),
        .i_wr_addr(wr.addr[AW-1:0]),
        .i_wr_data(wr.data),
        .i_rd_en  (accept),
        .i_rd_addr(i_in.read_index[AW-1:0]),
        .o_rd_data(rd_data)
    );

    // Read stage: waits for the buffer data while the status settles.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_read <= (i_in.cmd == CMD_READ) && rd_in_buf;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out.packet_ready <= status.packet_ready;
            r_out.payload_size <= status.payload_size;
            r_out.read_data    <= r_s1_read ? rd_data : 8'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
